@@ design/csv_field_splitter_sjis_unit_defines.svh @@
// ----------------------------------------------------------------------------
// CSV field splitter assertion macros
// Shared concurrent assertion forms for the splitter checker.
// ----------------------------------------------------------------------------
`ifndef CSV_FIELD_SPLITTER_SJIS_UNIT_DEFINES_SVH
`define CSV_FIELD_SPLITTER_SJIS_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define CSVS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("csv splitter check failed");

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define CSVS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("csv splitter check failed");

`endif

@@ design/csvs_pkg.sv @@
// ----------------------------------------------------------------------------
// CSV field splitter package
// Item types, parser modes, byte constants and byte class functions.
// ----------------------------------------------------------------------------
package csvs_pkg;

    localparam logic [7:0]  QUOTE_BYTE  = 8'h22;
    localparam logic [7:0]  COMMA_BYTE  = 8'h2C;
    localparam logic [7:0]  SPACE_BYTE  = 8'h20;
    localparam logic [7:0]  CTRL_WS_LO  = 8'h09;
    localparam logic [7:0]  CTRL_WS_HI  = 8'h0D;
    localparam logic [7:0]  LEAD_A_LO   = 8'h80;
    localparam logic [7:0]  LEAD_A_HI   = 8'h9F;
    localparam logic [7:0]  LEAD_B_LO   = 8'hE0;
    localparam logic [15:0] FIELD_MAX   = 16'hFFFF;

    typedef enum logic [1:0] {
        MODE_SKIP   = 2'd0,
        MODE_PLAIN  = 2'd1,
        MODE_QUOTED = 2'd2,
        MODE_DROP   = 2'd3
    } t_mode;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       record_last;
    } t_in_item;

    typedef struct packed {
        logic [7:0]  echo_byte;
        logic        is_content;
        logic [15:0] field_index;
        logic        starts_field;
        logic        ends_field;
        logic        record_end;
        logic [15:0] field_count;
    } t_out_item;

    // Double-byte lead bytes; the upper range runs to 0xFF.
    function automatic logic is_lead(input logic [7:0] b);
        return ((b >= LEAD_A_LO) && (b <= LEAD_A_HI)) || (b >= LEAD_B_LO);
    endfunction

    function automatic logic is_blank(input logic [7:0] b);
        return (b == SPACE_BYTE) || ((b >= CTRL_WS_LO) && (b <= CTRL_WS_HI));
    endfunction

endpackage

@@ design/csvs_parse.sv @@
// ----------------------------------------------------------------------------
// CSV field splitter parser
// Holds the parse state and tags one registered byte per cycle while i_advance is high.
// ----------------------------------------------------------------------------
module csvs_parse
    import csvs_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_advance,
    input  t_in_item  i_item,
    output t_out_item o_result
);

    t_mode       r_mode,  n_mode,  u_mode;
    logic        r_trail, n_trail, u_trail;
    logic [15:0] r_count, n_count, u_count;

    logic [7:0] b;
    logic       skip_blank;

    assign b          = i_item.data_byte;
    assign skip_blank = (r_mode == MODE_SKIP) && is_blank(b);

    // Next state: the updated state, or the reset state after the last byte.
    always_comb begin
        u_mode  = r_mode;
        u_trail = r_trail;
        u_count = r_count;
        if (skip_blank) begin
            u_mode = r_mode;
        end else if (r_mode == MODE_SKIP) begin
            if (r_count != FIELD_MAX) begin
                u_count = r_count + 16'd1;
            end
            if (b == QUOTE_BYTE) begin
                u_mode = MODE_QUOTED;
            end else if (b != COMMA_BYTE) begin
                u_mode  = MODE_PLAIN;
                u_trail = is_lead(b);
            end
        end else if (r_trail) begin
            u_trail = 1'b0;
        end else if (is_lead(b)) begin
            u_trail = 1'b1;
        end else if (r_mode == MODE_QUOTED) begin
            if (b == QUOTE_BYTE) begin
                u_mode = MODE_DROP;
            end
        end else if (b == COMMA_BYTE) begin
            u_mode = MODE_SKIP;
        end
        if (i_item.record_last) begin
            n_mode  = MODE_SKIP;
            n_trail = 1'b0;
            n_count = '0;
        end else begin
            n_mode  = u_mode;
            n_trail = u_trail;
            n_count = u_count;
        end
    end

    // Result tags for the byte.
    always_comb begin
        o_result              = '0;
        o_result.echo_byte    = b;
        o_result.record_end   = i_item.record_last;
        o_result.field_count  = u_count;
        o_result.field_index  = skip_blank ? r_count : (u_count - 16'd1);
        if (skip_blank) begin
            o_result.is_content = 1'b0;
        end else if (r_mode == MODE_SKIP) begin
            o_result.starts_field = 1'b1;
            o_result.ends_field   = (b == COMMA_BYTE);
            o_result.is_content   = (b != COMMA_BYTE) && (b != QUOTE_BYTE);
        end else if (r_trail || is_lead(b)) begin
            o_result.is_content = (r_mode != MODE_DROP);
        end else if (r_mode == MODE_QUOTED) begin
            o_result.is_content = (b != QUOTE_BYTE);
        end else if (b == COMMA_BYTE) begin
            o_result.ends_field = 1'b1;
        end else begin
            o_result.is_content = (r_mode == MODE_PLAIN);
        end
        if (i_item.record_last && (u_mode != MODE_SKIP)) begin
            o_result.ends_field = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_SKIP;
            r_trail <= 1'b0;
            r_count <= '0;
        end else if (i_advance) begin
            r_mode  <= n_mode;
            r_trail <= n_trail;
            r_count <= n_count;
        end
    end

endmodule

@@ design/csv_field_splitter_sjis_unit.sv @@
// ----------------------------------------------------------------------------
// CSV field splitter for Shift-JIS records
// Tags each record byte with field position, content and boundary flags.
// ----------------------------------------------------------------------------
// Usage:
// Bytes of a record enter on the input channel (i_in_valid, o_in_stall,
// i_in_item), with record_last set on the final byte of each record. Every
// byte yields exactly one tagged result on the output channel (o_out_valid,
// i_out_stall, o_out_item), in order.
// A byte transferred at a clock edge is held in the input register, tagged
// by the parser and lands in the output register when the parser advances;
// its result is then offered there and can transfer out. One byte is taken
// every cycle while o_in_stall is low; the only loop is the parse state
// (mode, trail flag, field counter), which updates once per byte.
// Synchronous active-low reset empties both registers and returns the parser
// to whitespace skipping with a field count of zero; the parser also returns
// there after each record's last byte.
// When the receiver stalls, the output register holds its result, the input
// register keeps one more byte, and the input stalls only once both are full.
// ----------------------------------------------------------------------------
module csv_field_splitter_sjis_unit
    import csvs_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    logic      r_in_valid;
    t_in_item  r_in_item;
    logic      r_out_valid;
    t_out_item r_out_item;
    t_out_item parse_result;
    logic      out_blocked;
    logic      advance;

    assign out_blocked = r_out_valid && i_out_stall;
    assign advance     = r_in_valid && !out_blocked;
    assign o_in_stall  = r_in_valid && out_blocked;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    csvs_parse u_parse (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_item    (r_in_item),
        .o_result  (parse_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in_item <= i_in_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (!out_blocked) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_item <= parse_result;
        end
    end

endmodule

@@ design/csvs_chk.sv @@
// ----------------------------------------------------------------------------
// CSV field splitter checker
// Port-level assertions on the splitter, attached to the top level by bind.
// ----------------------------------------------------------------------------
`include "csv_field_splitter_sjis_unit_defines.svh"

module csvs_chk
    import csvs_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_in_stall,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_item o_out_item
);

    // An opening byte always carries the index of the field it just counted.
    `CSVS_ASSERT_NOW(a_start_index, i_clk, i_rst_n, o_out_valid && o_out_item.starts_field, o_out_item.field_index == (o_out_item.field_count - 16'd1))
    // Content can only appear once some field has been opened.
    `CSVS_ASSERT_NOW(a_content_count, i_clk, i_rst_n, o_out_valid && o_out_item.is_content, o_out_item.field_count != 16'd0)
    // The input side only stalls when a finished result is being held back.
    `CSVS_ASSERT_NOW(a_stall_cause, i_clk, i_rst_n, o_in_stall, o_out_valid && i_out_stall)
    // A held result does not change while the receiver stalls.
    `CSVS_ASSERT_NEXT(a_hold_item, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_item))

endmodule

bind csv_field_splitter_sjis_unit csvs_chk u_chk (.*);
